// ===== hw/rtl/hsv2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared widths, limits, hue sector codes and the fixed-point reciprocal
// used to scale each colour channel to eight bits.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

    localparam int HUE_W  = 11;
    localparam int PCT_W  = 7;
    localparam int HREL_W = 9;
    localparam int SV_W   = 14;
    localparam int WGT_W  = 6;
    localparam int PART_W = 20;
    localparam int NUM_W  = 24;
    localparam int QIN_W  = 18;
    localparam int CH_W   = 8;

    localparam logic signed [HUE_W-1:0] HUE_MAX = 11'sd360;
    localparam logic [PCT_W-1:0]        PCT_MAX = 7'd100;

    // floor(n / 625) == (n * RECIP) >> RECIP_SHIFT for every n below 2**QIN_W.
    localparam int RECIP_W     = 19;
    localparam int RECIP_SHIFT = 28;
    localparam int PROD_W      = QIN_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = 19'd429497;
    localparam int PRE_SHIFT   = 6;

    typedef logic [2:0] sector_t;

    localparam sector_t SEC_CX0 = 3'd0;
    localparam sector_t SEC_XC0 = 3'd1;
    localparam sector_t SEC_0CX = 3'd2;
    localparam sector_t SEC_0XC = 3'd3;
    localparam sector_t SEC_X0C = 3'd4;
    localparam sector_t SEC_C0X = 3'd5;

endpackage

// ===== hw/rtl/hsv2rgb_scale.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_scale
// Divides a pre-shifted channel numerator by 625 through a multiplication
// by a rounded-up fixed-point reciprocal, exact for every numerator, giving the eight-bit channel value.
// ----------------------------------------------------------------------------
module hsv2rgb_scale
    import hsv2rgb_pkg::*;
(
    input  logic [QIN_W-1:0] num,
    output logic [CH_W-1:0]  chan
);

    logic [PROD_W-1:0] prod;

    assign prod = PROD_W'(num) * PROD_W'(RECIP);
    assign chan = prod[RECIP_SHIFT +: CH_W];

endmodule

// ===== hw/rtl/hsv_to_rgb_converter_top.sv =====
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_top
// Converts one HSV colour per transfer into eight-bit red, green and blue.
//
//  Channel   Dir  Fields (lowest bit first)
//  s_axis    in   tdata: hue_deg[10:0] sat_pct[17:11] val_pct[24:18]
//  m_axis    out  tdata: red[7:0] green[15:8] blue[23:16]; tuser: out_of_range
//
// One transfer is accepted every cycle while the output is not stalled; each
// result passes through the four register stages: stages 1 to 3 and the output register.
// The multiplier in the final stage sets the clock rate.
// Reset clears only the stage valid bits. Backpressure stalls each stage
// only when it is occupied, so bubbles are squeezed out during a stall.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_top
    import hsv2rgb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // hue_deg, sat_pct, val_pct, zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // red, green, blue
    output logic        m_axis_tuser    // out_of_range
);

    logic signed [HUE_W-1:0] hue_deg;
    logic [PCT_W-1:0]        sat_pct;
    logic [PCT_W-1:0]        val_pct;

    logic rdy1;
    logic rdy2;
    logic rdy3;
    logic rdy_o;

    // Stage 1: range check, sector, hue weight and S*V.
    logic                v1_reg,   v1_next;
    logic                err1_reg, err1_next;
    logic [SV_W-1:0]     sv1_reg,  sv1_next;
    logic [PCT_W-1:0]    val1_reg;
    logic [WGT_W-1:0]    w1_reg,   w1_next;
    sector_t             sec1_reg, sec1_next;
    logic [HREL_W-1:0]   h9;
    logic [PCT_W-1:0]    hm;
    logic [WGT_W-1:0]    hdist;

    // Stage 2: C, X and m.
    logic                v2_reg;
    logic                err2_reg;
    logic [PART_W-1:0]   c2_reg,   c2_next;
    logic [PART_W-1:0]   x2_reg,   x2_next;
    logic [PART_W-1:0]   m2_reg,   m2_next;
    sector_t             sec2_reg;

    // Stage 3: scaled channel numerators.
    logic                v3_reg;
    logic                err3_reg;
    logic [QIN_W-1:0]    q3_reg   [3];
    logic [QIN_W-1:0]    q3_next  [3];
    logic [PART_W-1:0]   part     [3];

    // Output register.
    logic                ov_reg;
    logic                oor_reg;
    logic [CH_W-1:0]     rgb_reg  [3];
    logic [CH_W-1:0]     rgb_next [3];

    assign hue_deg = $signed(s_axis_tdata[HUE_W-1:0]);
    assign sat_pct = s_axis_tdata[HUE_W +: PCT_W];
    assign val_pct = s_axis_tdata[HUE_W+PCT_W +: PCT_W];

    assign rdy_o = !ov_reg || m_axis_tready;
    assign rdy3  = !v3_reg || rdy_o;
    assign rdy2  = !v2_reg || rdy3;
    assign rdy1  = !v1_reg || rdy2;
    assign s_axis_tready = rdy1;

    assign v1_next   = s_axis_tvalid;
    assign err1_next = (hue_deg < 0) || (hue_deg > HUE_MAX)
                       || (sat_pct > PCT_MAX) || (val_pct > PCT_MAX);
    assign sv1_next  = SV_W'(sat_pct) * SV_W'(val_pct);
    assign h9        = hue_deg[HREL_W-1:0];

    always_comb
    begin
        if (h9 < 9'd120)
        begin
            hm = PCT_W'(h9);
        end
        else if (h9 < 9'd240)
        begin
            hm = PCT_W'(h9 - 9'd120);
        end
        else if (h9 < 9'd360)
        begin
            hm = PCT_W'(h9 - 9'd240);
        end
        else
        begin
            hm = '0;
        end

        if (hm >= 7'd60)
        begin
            hdist = WGT_W'(hm - 7'd60);
        end
        else
        begin
            hdist = WGT_W'(7'd60 - hm);
        end

        if (h9 < 9'd60)
        begin
            sec1_next = SEC_CX0;
        end
        else if (h9 < 9'd120)
        begin
            sec1_next = SEC_XC0;
        end
        else if (h9 < 9'd180)
        begin
            sec1_next = SEC_0CX;
        end
        else if (h9 < 9'd240)
        begin
            sec1_next = SEC_0XC;
        end
        else if (h9 < 9'd300)
        begin
            sec1_next = SEC_X0C;
        end
        else
        begin
            sec1_next = SEC_C0X;
        end
    end

    assign w1_next = WGT_W'(6'd60 - hdist);

    assign c2_next = PART_W'(sv1_reg) * PART_W'(6'd60);
    assign x2_next = PART_W'(sv1_reg) * PART_W'(w1_reg);
    assign m2_next = PART_W'(PART_W'(val1_reg) * PART_W'(13'd6000)) - c2_next;

    always_comb
    begin
        unique case (sec2_reg)
            SEC_CX0:
            begin
                part[0] = c2_reg;  part[1] = x2_reg;  part[2] = '0;
            end
            SEC_XC0:
            begin
                part[0] = x2_reg;  part[1] = c2_reg;  part[2] = '0;
            end
            SEC_0CX:
            begin
                part[0] = '0;      part[1] = c2_reg;  part[2] = x2_reg;
            end
            SEC_0XC:
            begin
                part[0] = '0;      part[1] = x2_reg;  part[2] = c2_reg;
            end
            SEC_X0C:
            begin
                part[0] = x2_reg;  part[1] = '0;      part[2] = c2_reg;
            end
            default:
            begin
                part[0] = c2_reg;  part[1] = '0;      part[2] = x2_reg;
            end
        endcase
    end

    // 255 / 600000 == 17 / (64 * 625): multiply by 17 and drop six bits here.
    generate
        for (genvar i = 0; i < 3; i++)
        begin : g_chan
            logic [PART_W-1:0] sum;
            logic [NUM_W-1:0]  num;

            assign sum        = part[i] + m2_reg;
            assign num        = (NUM_W'(sum) << 4) + NUM_W'(sum);
            assign q3_next[i] = num[PRE_SHIFT +: QIN_W];

            hsv2rgb_scale u_scale
            (
                .num  (q3_reg[i]),
                .chan (rgb_next[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= v1_next;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy_o)
            begin
                ov_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            err1_reg <= err1_next;
            sv1_reg  <= sv1_next;
            val1_reg <= val_pct;
            w1_reg   <= w1_next;
            sec1_reg <= sec1_next;
        end
        if (rdy2)
        begin
            err2_reg <= err1_reg;
            c2_reg   <= c2_next;
            x2_reg   <= x2_next;
            m2_reg   <= m2_next;
            sec2_reg <= sec1_reg;
        end
        if (rdy3)
        begin
            err3_reg <= err2_reg;
            q3_reg   <= q3_next;
        end
        if (rdy_o)
        begin
            oor_reg <= err3_reg;
            for (int i = 0; i < 3; i++)
            begin
                rgb_reg[i] <= err3_reg ? '0 : rgb_next[i];
            end
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {rgb_reg[2], rgb_reg[1], rgb_reg[0]};
    assign m_axis_tuser  = oor_reg;

`ifndef SYNTHESIS
    // A valid colour never has a sector code outside the six sectors.
    a_sector_code: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && !err1_reg |-> sec1_reg <= SEC_C0X)
        else $error("hue sector code out of range");

    a_hue_weight: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && !err1_reg |-> w1_reg <= 6'd60)
        else $error("hue weight above sixty");

    // C plus m is the full value V * 6000 and so never exceeds the scale.
    a_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && !err2_reg |-> (21'(c2_reg) + 21'(m2_reg)) <= 21'd600000)
        else $error("channel numerator exceeds full scale");

    a_err_black: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 24'd0)
        else $error("out-of-range transfer carries a non-zero colour");

    // Stage 3, when held, must not lose its item to the next cycle.
    a_stall_keep: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && !rdy3 |=> v3_reg)
        else $error("stalled stage dropped its item");
`endif

endmodule
